>>> rtl/abtt_pkg.sv
// Shared constants and types for the array binary tree traversal block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package abtt_pkg;

  localparam int NODES      = 63;
  localparam int TREE_DEPTH = 6;
  localparam int IDX_W      = 6;
  localparam int VAL_W      = 32;
  localparam int CHILD_W    = IDX_W + 1;
  localparam int SP_W       = $clog2(TREE_DEPTH + 1);
  localparam int STK_AW     = (TREE_DEPTH > 1) ? $clog2(TREE_DEPTH) : 1;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_PRE    = 2'd1;
  localparam logic [1:0] OP_IN     = 2'd2;
  localparam logic [1:0] OP_POST   = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_USED  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;
  localparam logic [1:0] STAT_EMPTY = 2'd3;

  localparam logic [1:0] PH_LEFT  = 2'd0;
  localparam logic [1:0] PH_RIGHT = 2'd1;
  localparam logic [1:0] PH_DONE  = 2'd2;

  // Kind of event handed from the walk controller to the output buffer.
  typedef enum logic [1:0] {
    EV_VISIT  = 2'd0,
    EV_FINAL  = 2'd1,
    EV_SINGLE = 2'd2
  } ev_kind_e;

  typedef struct packed {
    ev_kind_e         kind;
    logic [IDX_W-1:0] idx;
    logic [1:0]       status;
  } ev_t;

  typedef struct packed {
    logic [1:0]       phase;
    logic [IDX_W-1:0] slot;
  } stk_entry_t;

endpackage

>>> rtl/abtt_node_ram.sv
// Node value store: single write port, single read port, registered read data.
// Depends on abtt_pkg for depth and widths.
`timescale 1ns / 1ps

module abtt_node_ram import abtt_pkg::*; (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  logic [VAL_W-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output logic [VAL_W-1:0] rd_data_o
);

  logic [VAL_W-1:0] mem_q [NODES];
  logic [VAL_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/abtt_walk_ctrl.sv
// Sequencer for inserts and depth-first walks: used marks, walk stack and
// the event stage towards the output buffer. Depends on abtt_pkg.
`timescale 1ns / 1ps

module abtt_walk_ctrl import abtt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       in_op_i,
  input  logic [IDX_W-1:0] in_index_i,
  input  logic [VAL_W-1:0] in_value_i,
  input  logic             buf_ready_i,
  output logic             ev_valid_o,
  output ev_t              ev_o,
  output logic             ram_wr_en_o,
  output logic [IDX_W-1:0] ram_wr_addr_o,
  output logic [VAL_W-1:0] ram_wr_data_o,
  output logic             ram_rd_en_o,
  output logic [IDX_W-1:0] ram_rd_addr_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [SP_W-1:0]  sp_q, sp_d;
  logic [NODES-1:0] used_q, used_d;
  logic [1:0]       op_q, op_d;
  stk_entry_t       stack_q [TREE_DEPTH];
  stk_entry_t       stack_d [TREE_DEPTH];
  logic             ev_valid_q, ev_valid_d;
  ev_t              ev_q, ev_d;

  logic               advance;
  logic [SP_W-1:0]    top;
  stk_entry_t         top_ent;
  logic [1:0]         emit_phase;
  logic [CHILD_W-1:0] child;
  logic [IDX_W-1:0]   child_idx;
  logic               child_ok;
  logic               in_range;

  // The event stage moves on whenever it is empty or the buffer takes it.
  assign advance    = !ev_valid_q || buf_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && advance;

  assign top        = sp_q - SP_W'(1);
  assign top_ent    = stack_q[top[STK_AW-1:0]];
  assign emit_phase = op_q - 2'd1;
  assign child      = CHILD_W'({top_ent.slot, 1'b0}) + CHILD_W'(top_ent.phase) + CHILD_W'(1);
  assign child_idx  = child[IDX_W-1:0];
  assign child_ok   = (child < CHILD_W'(NODES)) && used_q[child_idx]
                      && (sp_q < SP_W'(TREE_DEPTH));
  assign in_range   = CHILD_W'(in_index_i) < CHILD_W'(NODES);

  always_comb begin
    state_d       = state_q;
    sp_d          = sp_q;
    used_d        = used_q;
    op_d          = op_q;
    stack_d       = stack_q;
    ev_valid_d    = ev_valid_q;
    ev_d          = ev_q;
    ram_wr_en_o   = 1'b0;
    ram_wr_addr_o = in_index_i;
    ram_wr_data_o = in_value_i;
    ram_rd_en_o   = 1'b0;
    ram_rd_addr_o = top_ent.slot;

    if (advance) begin
      ev_valid_d = 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (in_op_i == OP_INSERT) begin
              ev_valid_d  = 1'b1;
              ev_d.kind   = EV_SINGLE;
              ev_d.idx    = in_index_i;
              if (!in_range) begin
                ev_d.status = STAT_RANGE;
              end else if (used_q[in_index_i]) begin
                ev_d.status = STAT_USED;
              end else begin
                ev_d.status            = STAT_OK;
                ram_wr_en_o            = 1'b1;
                used_d[in_index_i]     = 1'b1;
              end
            end else begin
              op_d = in_op_i;
              if (used_q[0]) begin
                stack_d[0].slot  = '0;
                stack_d[0].phase = PH_LEFT;
                sp_d             = SP_W'(1);
                state_d          = S_WALK;
              end else begin
                // Root unused: a single empty-tree result.
                ev_valid_d  = 1'b1;
                ev_d.kind   = EV_SINGLE;
                ev_d.idx    = '0;
                ev_d.status = STAT_EMPTY;
              end
            end
          end
        end
        S_WALK: begin
          if (top_ent.phase == emit_phase) begin
            ram_rd_en_o = 1'b1;
            ev_valid_d  = 1'b1;
            ev_d.kind   = EV_VISIT;
            ev_d.idx    = top_ent.slot;
            ev_d.status = STAT_OK;
          end
          if (top_ent.phase >= PH_DONE) begin
            sp_d = top;
            if (top == '0) begin
              state_d = S_FIN;
            end
          end else begin
            stack_d[top[STK_AW-1:0]].phase = top_ent.phase + 2'd1;
            if (child_ok) begin
              stack_d[sp_q[STK_AW-1:0]].slot  = child_idx;
              stack_d[sp_q[STK_AW-1:0]].phase = PH_LEFT;
              sp_d = sp_q + SP_W'(1);
            end
          end
        end
        S_FIN: begin
          ev_valid_d  = 1'b1;
          ev_d.kind   = EV_FINAL;
          ev_d.idx    = '0;
          ev_d.status = STAT_OK;
          state_d     = S_IDLE;
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      sp_q       <= '0;
      used_q     <= '0;
      ev_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      sp_q       <= sp_d;
      used_q     <= used_d;
      ev_valid_q <= ev_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    stack_q <= stack_d;
    ev_q    <= ev_d;
  end

  assign ev_valid_o = ev_valid_q;
  assign ev_o       = ev_q;

endmodule

>>> rtl/abtt_out_buf.sv
// Result buffer: holds one visited node back so that the final one can be
// marked last, and drives the output register. Depends on abtt_pkg.
`timescale 1ns / 1ps

module abtt_out_buf import abtt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             ev_valid_i,
  input  ev_t              ev_i,
  input  logic [VAL_W-1:0] ram_data_i,
  output logic             buf_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [VAL_W-1:0] out_value_o,
  output logic [IDX_W-1:0] out_index_o,
  output logic [1:0]       out_status_o,
  output logic             out_last_o
);

  logic             pend_v_q, pend_v_d;
  logic [VAL_W-1:0] pend_value_q, pend_value_d;
  logic [IDX_W-1:0] pend_idx_q, pend_idx_d;
  logic             out_v_q, out_v_d;
  logic [VAL_W-1:0] out_value_q, out_value_d;
  logic [IDX_W-1:0] out_idx_q, out_idx_d;
  logic [1:0]       out_status_q, out_status_d;
  logic             out_last_q, out_last_d;
  logic             take;

  assign buf_ready_o = !out_v_q || out_ready_i;
  assign take        = ev_valid_i && buf_ready_o;

  always_comb begin
    pend_v_d     = pend_v_q;
    pend_value_d = pend_value_q;
    pend_idx_d   = pend_idx_q;
    out_v_d      = out_v_q && !out_ready_i;
    out_value_d  = out_value_q;
    out_idx_d    = out_idx_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    if (take) begin
      unique case (ev_i.kind)
        EV_VISIT: begin
          if (pend_v_q) begin
            out_v_d      = 1'b1;
            out_value_d  = pend_value_q;
            out_idx_d    = pend_idx_q;
            out_status_d = STAT_OK;
            out_last_d   = 1'b0;
          end
          pend_v_d     = 1'b1;
          pend_value_d = ram_data_i;
          pend_idx_d   = ev_i.idx;
        end
        EV_FINAL: begin
          out_v_d      = 1'b1;
          out_value_d  = pend_value_q;
          out_idx_d    = pend_idx_q;
          out_status_d = STAT_OK;
          out_last_d   = 1'b1;
          pend_v_d     = 1'b0;
        end
        EV_SINGLE: begin
          out_v_d      = 1'b1;
          out_value_d  = '0;
          out_idx_d    = ev_i.idx;
          out_status_d = ev_i.status;
          out_last_d   = 1'b1;
        end
        default: begin
          out_v_d = out_v_q && !out_ready_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_value_q <= pend_value_d;
    pend_idx_q   <= pend_idx_d;
    out_value_q  <= out_value_d;
    out_idx_q    <= out_idx_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o  = out_v_q;
  assign out_value_o  = out_value_q;
  assign out_index_o  = out_idx_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

endmodule

>>> rtl/array_binary_tree_traversal_core.sv
// Top level of the array binary tree traversal block.
// Instantiates abtt_walk_ctrl, abtt_node_ram and abtt_out_buf; uses abtt_pkg.
`timescale 1ns / 1ps

// A binary tree of 63 slots is held as an implicit array: slot i has its
// children at 2i+1 and 2i+2. Items arrive on the slave stream; tuser carries
// the operation (insert, preorder, inorder or postorder walk) and tdata the
// slot index and the value to insert. Results leave on the master stream,
// one transfer per result, with tlast set on the final result of an item and
// the status code in tuser.
// An insert's result passes through the event stage and the output register
// after the input transfer. In a walk, each used slot it reaches is handled
// in three stack steps (left, right, done) on the walk stack registers, one
// step per cycle while the result buffer takes events. The node value is
// read from the single-port-read node memory in the step where the slot is
// emitted. One visit is held back in the result buffer so that the last can
// be flagged, so each visit of a walk leaves only once the next visit or the
// end of the walk reaches the buffer. A new item is accepted once the previous
// walk has left the sequencer, while its last results may still be draining.
// Reset clears all used marks (flip-flops, no clearing pass) and empties the
// stack and result buffer; node values are not cleared and are only read for
// used slots. When the receiver stalls, the output register holds, the held
// result and event stage fill, and the walk and the input side then stop
// until transfers resume; nothing is lost or repeated.

module array_binary_tree_traversal_core import abtt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [5:0] node_index, [37:6] node_value, [39:38] zero
  input  logic [39:0] s_axis_tdata,
  // [1:0] op
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] out_value, [37:32] out_index, [39:38] zero
  output logic [39:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  logic             buf_ready;
  logic             ev_valid;
  ev_t              ev;
  logic             ram_wr_en;
  logic [IDX_W-1:0] ram_wr_addr;
  logic [VAL_W-1:0] ram_wr_data;
  logic             ram_rd_en;
  logic [IDX_W-1:0] ram_rd_addr;
  logic [VAL_W-1:0] ram_rd_data;
  logic [VAL_W-1:0] out_value;
  logic [IDX_W-1:0] out_index;

  // The sequencer owns the used marks and the walk stack; it issues node
  // memory reads for slots being emitted and passes its events on to the buffer.
  abtt_walk_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_op_i       (s_axis_tuser),
    .in_index_i    (s_axis_tdata[IDX_W-1:0]),
    .in_value_i    (s_axis_tdata[IDX_W+VAL_W-1:IDX_W]),
    .buf_ready_i   (buf_ready),
    .ev_valid_o    (ev_valid),
    .ev_o          (ev),
    .ram_wr_en_o   (ram_wr_en),
    .ram_wr_addr_o (ram_wr_addr),
    .ram_wr_data_o (ram_wr_data),
    .ram_rd_en_o   (ram_rd_en),
    .ram_rd_addr_o (ram_rd_addr)
  );

  abtt_node_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // The read data stays put until the visit event that asked for it has
  // been taken by the buffer, as no further read is issued meanwhile.
  abtt_out_buf u_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ev_valid_i   (ev_valid),
    .ev_i         (ev),
    .ram_data_i   (ram_rd_data),
    .buf_ready_o  (buf_ready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_value_o  (out_value),
    .out_index_o  (out_index),
    .out_status_o (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_index, out_value};

endmodule

>>> tb/sv/array_binary_tree_traversal_core_test.sv
// Self-checking testbench for array_binary_tree_traversal_core: directed table, then random items.
// Depends on abtt_pkg and the block's RTL; expected results come from a behavioural tree model.
`timescale 1ns / 1ps

module array_binary_tree_traversal_core_test;
  import abtt_pkg::*;

  localparam int DIR_N       = 21;
  localparam int RAND_N      = 480;
  localparam int PHASE_LEN   = RAND_N / 4;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_WAIT  = 400;
  localparam int MAX_REPORTS = 60;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
    logic [1:0]       status;
    logic             last;
  } tree_result_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    bit               typed;
    logic [IDX_W-1:0] exp_idx;
    logic [1:0]       exp_st;
  } dir_row_t;

  // Rows with typed set carry their single result; the rest go through the tree model.
  dir_row_t dir_rows [DIR_N] = '{
    '{OP_PRE,    6'd63, 32'hFFFF_FFFF, 1'b1, 6'd0,  STAT_EMPTY},
    '{OP_IN,     6'd0,  32'h0000_0000, 1'b1, 6'd0,  STAT_EMPTY},
    '{OP_POST,   6'd21, 32'h1234_5678, 1'b1, 6'd0,  STAT_EMPTY},
    '{OP_INSERT, 6'd63, 32'h7FFF_FFFF, 1'b1, 6'd63, STAT_RANGE},
    '{OP_INSERT, 6'd0,  32'h8000_0000, 1'b1, 6'd0,  STAT_OK},
    '{OP_INSERT, 6'd0,  32'h0000_0001, 1'b1, 6'd0,  STAT_USED},
    '{OP_PRE,    6'd0,  32'h0000_0000, 1'b0, 6'd0,  STAT_OK},
    '{OP_INSERT, 6'd1,  32'h7FFF_FFFF, 1'b1, 6'd1,  STAT_OK},
    '{OP_INSERT, 6'd2,  32'h0000_0000, 1'b1, 6'd2,  STAT_OK},
    '{OP_INSERT, 6'd62, 32'hFFFF_FFFF, 1'b1, 6'd62, STAT_OK},
    '{OP_INSERT, 6'd4,  32'hAAAA_AAAA, 1'b1, 6'd4,  STAT_OK},
    '{OP_INSERT, 6'd5,  32'h5555_5555, 1'b1, 6'd5,  STAT_OK},
    '{OP_IN,     6'd63, 32'hFFFF_FFFF, 1'b0, 6'd0,  STAT_OK},
    '{OP_POST,   6'd7,  32'h0F0F_0F0F, 1'b0, 6'd0,  STAT_OK},
    '{OP_INSERT, 6'd6,  32'hDEAD_BEEF, 1'b1, 6'd6,  STAT_OK},
    '{OP_INSERT, 6'd14, 32'h0000_7FFF, 1'b1, 6'd14, STAT_OK},
    '{OP_INSERT, 6'd30, 32'hFFFF_8000, 1'b1, 6'd30, STAT_OK},
    '{OP_PRE,    6'd0,  32'h0000_0000, 1'b0, 6'd0,  STAT_OK},
    '{OP_IN,     6'd0,  32'h0000_0000, 1'b0, 6'd0,  STAT_OK},
    '{OP_POST,   6'd0,  32'h0000_0000, 1'b0, 6'd0,  STAT_OK},
    '{OP_INSERT, 6'd62, 32'h0000_0002, 1'b1, 6'd62, STAT_USED}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = OP_INSERT;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  idle_mode_e idle_mode = IDLE_NONE;
  int         hold_asks = 0;
  int         fail_count = 0;

  // Tree model state and its output for the item just accepted.
  bit               tree_used [NODES];
  logic [VAL_W-1:0] tree_val  [NODES];
  tree_result_t     step_results [$];
  tree_result_t     expected_results [$];

  array_binary_tree_traversal_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Insert or walk on the model tree; the walk keeps slot and phase per stack level.
  task automatic tree_model_step(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                                 input logic [VAL_W-1:0] val);
    int stk_slot [TREE_DEPTH];
    int stk_ph   [TREE_DEPTH];
    int sp, top, slot, ph, child, count;
    tree_result_t res;
    step_results.delete();
    res = '0;
    if (op == OP_INSERT) begin
      res.index = idx;
      res.last  = 1'b1;
      if (idx >= NODES) begin
        res.status = STAT_RANGE;
      end else if (tree_used[idx]) begin
        res.status = STAT_USED;
      end else begin
        tree_used[idx] = 1'b1;
        tree_val[idx]  = val;
        res.status     = STAT_OK;
      end
      step_results.push_back(res);
    end else begin
      sp    = 0;
      count = 0;
      if (tree_used[0]) begin
        stk_slot[0] = 0;
        stk_ph[0]   = 0;
        sp          = 1;
      end
      while (sp > 0 && count < NODES) begin
        top  = sp - 1;
        slot = stk_slot[top];
        ph   = stk_ph[top];
        if (ph == int'(op) - 1) begin
          res.value  = tree_val[slot];
          res.index  = slot[IDX_W-1:0];
          res.status = STAT_OK;
          res.last   = 1'b0;
          step_results.push_back(res);
          count++;
        end
        if (ph >= 2) begin
          sp--;
        end else begin
          stk_ph[top] = ph + 1;
          child       = 2 * slot + 1 + ph;
          if (child < NODES && sp < TREE_DEPTH) begin
            if (tree_used[child]) begin
              stk_slot[sp] = child;
              stk_ph[sp]   = 0;
              sp++;
            end
          end
        end
      end
      if (count == 0) begin
        res        = '0;
        res.status = STAT_EMPTY;
        res.last   = 1'b1;
        step_results.push_back(res);
      end else begin
        step_results[step_results.size() - 1].last = 1'b1;
      end
    end
  endtask

  // Offers one item from a falling edge, waits for its transfer, then records what it should give.
  task automatic send_item(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] val, input bit typed,
                           input tree_result_t typed_res);
    while ((idle_mode == IDLE_SEND && $urandom_range(99) < 80) ||
           (idle_mode == IDLE_BOTH && $urandom_range(99) < 10)) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, val, idx};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    tree_model_step(op, idx, val);
    if (typed) begin
      expected_results.push_back(typed_res);
    end else begin
      foreach (step_results[k]) expected_results.push_back(step_results[k]);
    end
    @(negedge clk_i);
  endtask

  function automatic void check_field(input string name, input logic [VAL_W-1:0] want,
                                      input logic [VAL_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Receiver: random back-pressure by phase, plus a long counted hold-off when asked.
  initial begin : result_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (idle_mode == IDLE_RECV) begin
        m_axis_tready <= ($urandom_range(99) >= 80);
      end else if (idle_mode == IDLE_BOTH) begin
        m_axis_tready <= ($urandom_range(99) >= 10);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Every output transfer is matched against the oldest outstanding expectation.
  always @(posedge clk_i) begin : result_check
    tree_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %h %h %h %b", $time,
                   m_axis_tdata[31:0], m_axis_tdata[37:32], m_axis_tuser, m_axis_tlast);
      end else begin
        want = expected_results.pop_front();
        check_field("out_value", want.value, m_axis_tdata[31:0]);
        check_field("out_index", VAL_W'(want.index), VAL_W'(m_axis_tdata[37:32]));
        check_field("status", VAL_W'(want.status), VAL_W'(m_axis_tuser));
        check_field("last", VAL_W'(want.last), VAL_W'(m_axis_tlast));
      end
    end
  end

  initial begin : stimulus
    tree_result_t     row_res;
    logic [1:0]       op;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    int               cand [$];
    int               pick;

    foreach (tree_used[n]) begin
      tree_used[n] = 1'b0;
      tree_val[n]  = '0;
    end
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table: empty walks, range and used refusals, extreme values, a path
    // down to the deepest level and a used slot hidden below a free one.
    idle_mode = IDLE_NONE;
    foreach (dir_rows[r]) begin
      row_res        = '0;
      row_res.index  = dir_rows[r].exp_idx;
      row_res.status = dir_rows[r].exp_st;
      row_res.last   = 1'b1;
      send_item(dir_rows[r].op, dir_rows[r].idx, dir_rows[r].val, dir_rows[r].typed, row_res);
    end

    // Random part: walks mixed with inserts that often grow the reachable tree,
    // and some that land anywhere, on used slots or out of range.
    row_res = '0;
    for (int i = 0; i < RAND_N; i++) begin
      idle_mode = idle_mode_e'(i / PHASE_LEN);
      if (i == 0) hold_asks++;
      case ($urandom_range(7))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        2:       val = 32'h0000_0000;
        3:       val = 32'hFFFF_FFFF;
        default: val = $urandom;
      endcase
      idx = IDX_W'($urandom_range(63));
      if ($urandom_range(99) < 30) begin
        op = 2'($urandom_range(OP_POST, OP_PRE));
      end else begin
        op   = OP_INSERT;
        pick = $urandom_range(99);
        cand.delete();
        for (int n = 0; n < NODES; n++)
          if (!tree_used[n] && (n == 0 || tree_used[(n - 1) / 2])) cand.push_back(n);
        if (pick < 45 && cand.size() != 0)
          idx = IDX_W'(cand[$urandom_range(cand.size() - 1)]);
        else if (pick >= 90)
          idx = IDX_W'(NODES);
      end
      send_item(op, idx, val, 1'b0, row_res);
    end

    s_axis_tvalid <= 1'b0;
    idle_mode = IDLE_NONE;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #30_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
